// ----- design/vpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpm_pkg
// Shared widths, stream packing offsets, store entry type and the
// control/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package vpm_pkg;

    localparam int ID_W    = 50;
    localparam int COORD_W = 27;
    localparam int TIME_W  = 17;

    localparam logic [COORD_W-1:0] WINDOW_RESET = COORD_W'(100);

    // Results given per request at most; further matches are dropped
    localparam int RESULT_LIMIT = 63;
    localparam int FOUND_W      = $clog2(RESULT_LIMIT + 1);

    // Slave tdata layout, lowest bit first
    localparam int S_ID_LO  = 0;
    localparam int S_SX_LO  = S_ID_LO + ID_W;
    localparam int S_SY_LO  = S_SX_LO + COORD_W;
    localparam int S_EX_LO  = S_SY_LO + COORD_W;
    localparam int S_EY_LO  = S_EX_LO + COORD_W;
    localparam int S_TS_LO  = S_EY_LO + COORD_W;
    localparam int S_TE_LO  = S_TS_LO + TIME_W;
    localparam int S_USED_W = S_TE_LO + TIME_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // Master tdata layout: earlier_id, then current_id
    localparam int M_USED_W  = 2 * ID_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] mid_x;
        logic [COORD_W-1:0] mid_y;
        logic [TIME_W-1:0]  t_start;
        logic [TIME_W-1:0]  t_end;
    } entry_t;

    typedef struct packed {
        logic start;   // take the request on s_tdata
        logic scan;    // walk the store
        logic flush;   // send the held match as the last one
    } vpm_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic pend_vld;
        logic out_free;
    } vpm_status_t;

endpackage

// ----- design/vpm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpm_ctrl
// Sequencer: accept one request, scan the store, flush the final match.
// ----------------------------------------------------------------------------
module vpm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  vpm_pkg::vpm_status_t status,
    output vpm_pkg::vpm_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!status.pend_vld || status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cmd.start = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.scan  = (state_reg == ST_SCAN);
    assign cmd.flush = (state_reg == ST_FLUSH);

endmodule

// ----- design/vpm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpm_datapath
// Record store, compare of one entry per cycle unless the output stalls, held match and output register.
// ----------------------------------------------------------------------------
module vpm_datapath #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  vpm_pkg::vpm_cmd_t                  cmd,
    output vpm_pkg::vpm_status_t               status,
    input  logic                               cfg_valid,
    input  logic [vpm_pkg::COORD_W-1:0]        cfg_data,
    input  logic [vpm_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vpm_pkg::ID_W-1:0]           m_earlier_id,
    output logic [vpm_pkg::ID_W-1:0]           m_current_id,
    output logic                               m_last
);

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_RECORDS);

    vpm_pkg::entry_t mem [MAX_RECORDS];

    logic [vpm_pkg::COORD_W-1:0] win_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               n_reg;
    logic [CW-1:0]               rd_idx_reg;
    logic                        rd_vld_reg;
    vpm_pkg::entry_t             rd_data_reg;
    vpm_pkg::entry_t             cur_reg;
    logic [vpm_pkg::FOUND_W-1:0] found_reg;
    logic                        pend_vld_reg;
    logic [vpm_pkg::ID_W-1:0]    pend_id_reg;
    logic                        m_tvalid_reg;
    logic [vpm_pkg::ID_W-1:0]    m_earlier_reg;
    logic [vpm_pkg::ID_W-1:0]    m_current_reg;
    logic                        m_last_reg;

    vpm_pkg::entry_t             new_entry;
    logic [vpm_pkg::COORD_W:0]   sum_x;
    logic [vpm_pkg::COORD_W:0]   sum_y;
    logic [CW-1:0]               acc_n;
    logic                        acc_store;
    logic [vpm_pkg::COORD_W-1:0] dx;
    logic [vpm_pkg::COORD_W-1:0] dy;
    logic                        overlap;
    logic                        hit;
    logic                        out_free;
    logic                        stall;
    logic                        rd_en;
    logic                        emit_mid;
    logic                        emit_last;

    // Unpack the request and form the midpoint
    always_comb begin
        sum_x = {1'b0, s_tdata[vpm_pkg::S_SX_LO +: vpm_pkg::COORD_W]}
              + {1'b0, s_tdata[vpm_pkg::S_EX_LO +: vpm_pkg::COORD_W]};
        sum_y = {1'b0, s_tdata[vpm_pkg::S_SY_LO +: vpm_pkg::COORD_W]}
              + {1'b0, s_tdata[vpm_pkg::S_EY_LO +: vpm_pkg::COORD_W]};
        new_entry.id      = s_tdata[vpm_pkg::S_ID_LO +: vpm_pkg::ID_W];
        new_entry.mid_x   = sum_x[vpm_pkg::COORD_W:1];
        new_entry.mid_y   = sum_y[vpm_pkg::COORD_W:1];
        new_entry.t_start = s_tdata[vpm_pkg::S_TS_LO +: vpm_pkg::TIME_W];
        new_entry.t_end   = s_tdata[vpm_pkg::S_TE_LO +: vpm_pkg::TIME_W];
        acc_n     = s_tuser ? '0 : count_reg;
        acc_store = (acc_n < CAP);
    end

    // Compare the current request against the entry last read from the store
    always_comb begin
        dx = (cur_reg.mid_x >= rd_data_reg.mid_x) ? cur_reg.mid_x - rd_data_reg.mid_x
                                                  : rd_data_reg.mid_x - cur_reg.mid_x;
        dy = (cur_reg.mid_y >= rd_data_reg.mid_y) ? cur_reg.mid_y - rd_data_reg.mid_y
                                                  : rd_data_reg.mid_y - cur_reg.mid_y;
        overlap = ((cur_reg.t_start <= rd_data_reg.t_start)
                   && (cur_reg.t_end >= rd_data_reg.t_start))
               || ((rd_data_reg.t_start <= cur_reg.t_start)
                   && (rd_data_reg.t_end >= cur_reg.t_start));
        hit = cmd.scan && rd_vld_reg && (dx <= win_reg) && (dy <= win_reg) && overlap
              && (found_reg < vpm_pkg::FOUND_W'(vpm_pkg::RESULT_LIMIT));
        out_free  = !m_tvalid_reg || m_tready;
        // A new hit pushes the held one out; hold the scan if the slot is busy
        stall     = hit && pend_vld_reg && !out_free;
        rd_en     = cmd.scan && !stall && (rd_idx_reg < n_reg);
        emit_mid  = hit && pend_vld_reg && out_free;
        emit_last = cmd.flush && pend_vld_reg && out_free;
    end

    assign status.scan_done = (rd_idx_reg == n_reg) && !rd_vld_reg;
    assign status.pend_vld  = pend_vld_reg;
    assign status.out_free  = out_free;

    // Store: write on accept while not full, one registered read per scan cycle unless stalled
    always_ff @(posedge aclk) begin
        if (cmd.start && acc_store) begin
            mem[acc_n[AW-1:0]] <= new_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= vpm_pkg::WINDOW_RESET;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            found_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                win_reg <= cfg_data;
            end
            if (cmd.start) begin
                count_reg    <= acc_store ? acc_n + CW'(1) : acc_n;
                rd_vld_reg   <= 1'b0;
                pend_vld_reg <= 1'b0;
                found_reg    <= '0;
            end else begin
                if (cmd.scan && !stall) begin
                    rd_vld_reg <= rd_en;
                end
                if (hit && !stall) begin
                    pend_vld_reg <= 1'b1;
                    found_reg    <= found_reg + vpm_pkg::FOUND_W'(1);
                end else if (emit_last) begin
                    pend_vld_reg <= 1'b0;
                end
            end
            if (emit_mid || emit_last) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cur_reg    <= new_entry;
            n_reg      <= acc_n;
            rd_idx_reg <= '0;
        end else if (rd_en) begin
            rd_idx_reg <= rd_idx_reg + CW'(1);
        end
        if (hit && !stall) begin
            pend_id_reg <= rd_data_reg.id;
        end
        if (emit_mid || emit_last) begin
            m_earlier_reg <= pend_id_reg;
            m_current_reg <= cur_reg.id;
            m_last_reg    <= emit_last;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_earlier_id = m_earlier_reg;
    assign m_current_id = m_current_reg;
    assign m_last       = m_last_reg;

endmodule

// ----- design/vehicle_proximity_matcher.sv -----
`timescale 1ns / 1ps
// A pair is held until the next match or the end of the scan. A new request is
// taken only after the previous scan and flush end; the scan walks the store through
// the single read port, one entry per cycle while the output does not stall.
// Reset: window returns to 100, the store is empty; no clearing pass runs.
// ----------------------------------------------------------------------------
// vehicle_proximity_matcher
// Matches each vehicle record against the records stored before it by midpoint
// distance and time overlap, one ID pair per match up to RESULT_LIMIT; stores it if room.
// ----------------------------------------------------------------------------
module vehicle_proximity_matcher #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: proximity_window
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vpm_pkg::COORD_W-1:0]      cfg_data,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // vehicle_id, start_x, start_y, end_x, end_y, start_sec, end_sec
    input  logic [vpm_pkg::S_TDATA_W-1:0]    s_tdata,
    // clear_store
    input  logic                             s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // earlier_id, current_id, zero pad
    output logic [vpm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast
);

    vpm_pkg::vpm_cmd_t        cmd;
    vpm_pkg::vpm_status_t     status;
    logic [vpm_pkg::ID_W-1:0] earlier_id;
    logic [vpm_pkg::ID_W-1:0] current_id;

    assign cfg_ready = 1'b1;

    vpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vpm_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_earlier_id (earlier_id),
        .m_current_id (current_id),
        .m_last       (m_tlast)
    );

    assign m_tdata = {{(vpm_pkg::M_TDATA_W - vpm_pkg::M_USED_W){1'b0}},
                      current_id, earlier_id};

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vehicle_proximity_matcher. Directed records probe
// the window edges, midpoint truncation, reversed and touching intervals and
// the clear flag. Clustered and random records then run under several window
// settings, including a saturated store that hits the per-request pair cap.
// Every accepted request is predicted here, and each pair on the result stream
// is checked in order. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import vpm_pkg::*;

    localparam int STORE_DEPTH  = 64;
    localparam int DRAIN_CYCLES = STORE_DEPTH + 16;
    localparam int SHOW_LIMIT   = 10;
    localparam int MAX_GAP      = 17;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [ID_W-1:0]    ID_MAX    = '1;

    typedef struct {
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [TIME_W-1:0]  ts;
        logic [TIME_W-1:0]  te;
    } vehicle_rec_t;

    typedef struct {
        logic [ID_W-1:0] earlier;
        logic [ID_W-1:0] current;
        logic            last;
    } id_pair_t;

    class match_predictor;
        logic [COORD_W-1:0] window;
        entry_t             store [STORE_DEPTH];
        int                 fill;
        id_pair_t           pending_pairs [$];
        int                 failures;
        int                 pairs_checked;
        int                 records_taken;
        int                 clears;
        int                 full_records;
        int                 capped_records;

        function new();
            window         = WINDOW_RESET;
            fill           = 0;
            failures       = 0;
            pairs_checked  = 0;
            records_taken  = 0;
            clears         = 0;
            full_records   = 0;
            capped_records = 0;
        endfunction

        function bit close_by(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
            logic [COORD_W-1:0] diff;
            diff = (a >= b) ? a - b : b - a;
            return diff <= window;
        endfunction

        function void take_record(logic clr, vehicle_rec_t r);
            entry_t           e;
            logic [COORD_W:0] sum_x;
            logic [COORD_W:0] sum_y;
            id_pair_t         p;
            int               hits;
            bit               overlap;
            records_taken++;
            if (clr) begin
                fill = 0;
                clears++;
            end
            sum_x     = {1'b0, r.sx} + {1'b0, r.ex};
            sum_y     = {1'b0, r.sy} + {1'b0, r.ey};
            e.id      = r.id;
            e.mid_x   = sum_x[COORD_W:1];
            e.mid_y   = sum_y[COORD_W:1];
            e.t_start = r.ts;
            e.t_end   = r.te;
            hits      = 0;
            for (int i = 0; i < fill; i++) begin
                overlap = (e.t_start <= store[i].t_start && e.t_end >= store[i].t_start) ||
                          (store[i].t_start <= e.t_start && store[i].t_end >= e.t_start);
                if (close_by(e.mid_x, store[i].mid_x) && close_by(e.mid_y, store[i].mid_y)
                        && overlap) begin
                    hits++;
                    // pairs past the cap are dropped
                    if (hits <= RESULT_LIMIT) begin
                        p.earlier = store[i].id;
                        p.current = e.id;
                        p.last    = 1'b0;
                        pending_pairs.push_back(p);
                    end
                end
            end
            if (hits > 0)
                pending_pairs[pending_pairs.size() - 1].last = 1'b1;
            if (hits > RESULT_LIMIT)
                capped_records++;
            if (fill < STORE_DEPTH) begin
                store[fill] = e;
                fill++;
            end else begin
                full_records++;
            end
        endfunction

        function void check_pair(logic [ID_W-1:0] earlier, logic [ID_W-1:0] current,
                                 logic last);
            id_pair_t p;
            if (pending_pairs.size() == 0) begin
                failures++;
                if (failures <= SHOW_LIMIT)
                    $display("unexpected pair: earlier %0d current %0d last %0b",
                             earlier, current, last);
                return;
            end
            p = pending_pairs.pop_front();
            pairs_checked++;
            if (earlier !== p.earlier || current !== p.current || last !== p.last) begin
                failures++;
                if (failures <= SHOW_LIMIT)
                    $display("pair mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                             p.earlier, p.current, p.last, earlier, current, last);
            end
        endfunction

        function int outstanding();
            return pending_pairs.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [COORD_W-1:0]     cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    match_predictor oracle;
    bit             no_gaps;
    bit             ready_steady;
    int             window_writes;

    vehicle_proximity_matcher #(
        .MAX_RECORDS(STORE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("timeout waiting on the result stream");
        $display("status: fail");
        $finish;
    end

    function automatic vehicle_rec_t rec(logic [ID_W-1:0] id,
                                         logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                         logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                                         logic [TIME_W-1:0] ts, logic [TIME_W-1:0] te);
        vehicle_rec_t r;
        r.id = id;
        r.sx = sx;
        r.sy = sy;
        r.ex = ex;
        r.ey = ey;
        r.ts = ts;
        r.te = te;
        return r;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ID_W-1:0];
    endfunction

    function automatic vehicle_rec_t random_record();
        return rec(rand_id(), COORD_W'($urandom()), COORD_W'($urandom()),
                   COORD_W'($urandom()), COORD_W'($urandom()),
                   TIME_W'($urandom()), TIME_W'($urandom()));
    endfunction

    function automatic int pick_center();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return int'(COORD_MAX);
            default: return int'($urandom_range(0, 99999999));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] near(int c, int s);
        int v;
        v = c - s + int'($urandom_range(0, 2 * s));
        if (v < 0)
            v = 0;
        if (v > int'(COORD_MAX))
            v = int'(COORD_MAX);
        return COORD_W'(v);
    endfunction

    function automatic logic [TIME_W-1:0] clip_time(int t);
        return (t > int'(TIME_MAX)) ? TIME_MAX : TIME_W'(t);
    endfunction

    task automatic send_record(input logic clr, input vehicle_rec_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid                      <= 1'b1;
        s_tuser                       <= clr;
        s_tdata[S_ID_LO +: ID_W]      <= r.id;
        s_tdata[S_SX_LO +: COORD_W]   <= r.sx;
        s_tdata[S_SY_LO +: COORD_W]   <= r.sy;
        s_tdata[S_EX_LO +: COORD_W]   <= r.ex;
        s_tdata[S_EY_LO +: COORD_W]   <= r.ey;
        s_tdata[S_TS_LO +: TIME_W]    <= r.ts;
        s_tdata[S_TE_LO +: TIME_W]    <= r.te;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        oracle.take_record(clr, r);
    endtask

    // Drop valid, let every predicted pair arrive, then cover the tail of a
    // scan that produces nothing.
    task automatic wait_for_results(input int limit);
        int waited;
        waited = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (oracle.outstanding() != 0 && waited < limit) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [COORD_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        oracle.window = value;
        window_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Records scattered around one spot in space and time, with some noise
    task automatic send_cluster(input int count, input int spread, input int tspan,
                                input bit clear_first);
        int           cx;
        int           cy;
        int           t0;
        int           ts;
        logic         clr;
        logic [TIME_W-1:0] swap;
        vehicle_rec_t r;
        cx = pick_center();
        cy = pick_center();
        t0 = $urandom_range(0, 86399);
        for (int k = 0; k < count; k++) begin
            clr = (k == 0 && clear_first) || ($urandom_range(0, 39) == 0);
            if ($urandom_range(0, 9) == 0) begin
                r = random_record();
            end else begin
                ts = t0 + int'($urandom_range(0, tspan));
                r  = rec(rand_id(), near(cx, spread), near(cy, spread),
                         near(cx, spread), near(cy, spread), clip_time(ts),
                         clip_time(ts + int'($urandom_range(0, tspan))));
                if ($urandom_range(0, 7) == 0) begin
                    swap = r.ts;
                    r.ts = r.te;
                    r.te = swap;
                end
            end
            send_record(clr, r);
        end
    endtask

    initial begin
        int w;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        no_gaps       = 1'b0;
        ready_steady  = 1'b0;
        window_writes = 0;
        oracle        = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // window at its reset value of 100
        send_record(1'b1, rec(0, 0, 0, 0, 0, 0, 0));
        send_record(1'b0, rec(ID_MAX, 0, 1, 1, 0, 0, 0));          // odd sums truncate
        send_record(1'b0, rec(1, 200, 0, 0, 0, 0, 5));              // exactly on the window
        send_record(1'b0, rec(2, 202, 0, 0, 0, 0, 5));              // one past it
        send_record(1'b0, rec(3, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              TIME_MAX, TIME_MAX));
        send_record(1'b0, rec(4, COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX,
                              TIME_MAX, 0));                          // reversed interval
        send_record(1'b0, rec(5, 0, 0, 0, 0, 10, 3));
        send_record(1'b0, rec(6, 0, 0, 0, 0, 5, 9));                // touches at second 5
        send_record(1'b0, rec(7, 0, 0, 0, 0, 6, 9));
        send_record(1'b1, rec(8, 0, 0, 0, 0, 0, 0));                // clear a busy store
        send_record(1'b0, rec(9, 0, 0, 0, 0, 0, 0));
        send_record(1'b0, rec(10, 100, 100, 100, 100, 0, 0));
        send_record(1'b0, rec(11, 0, 202, 0, 0, 0, 0));
        repeat (4) send_record(1'b0, random_record());
        wait_for_results(100000);

        // zero window: only equal midpoints pair up
        write_window('0);
        send_cluster(20, 1, 200, 1'b1);
        wait_for_results(100000);

        // widest window and overlapping times: fill the store and pass the cap
        write_window(COORD_MAX);
        ready_steady = ($urandom_range(0, 1) == 0);
        for (int k = 0; k < STORE_DEPTH + 3; k++)
            send_record(k == 0, rec(rand_id(), COORD_W'($urandom()), COORD_W'($urandom()),
                                    COORD_W'($urandom()), COORD_W'($urandom()),
                                    TIME_W'($urandom_range(0, 1000)),
                                    TIME_W'($urandom_range(86000, int'(TIME_MAX)))));
        ready_steady = 1'b0;
        wait_for_results(400000);

        for (int phase = 0; phase < 6; phase++) begin
            w = (phase == 3) ? int'(COORD_W'($urandom())) : $urandom_range(0, 4000);
            write_window(COORD_W'(w));
            for (int c = 0; c < 3; c++) begin
                no_gaps      = ($urandom_range(0, 3) == 0);
                ready_steady = ($urandom_range(0, 3) == 0);
                send_cluster($urandom_range(10, 18), w / 2 + 1, 300, $urandom_range(0, 2) == 0);
                // hold off now and then until the stream is empty
                if ($urandom_range(0, 2) == 0)
                    wait_for_results(200000);
            end
            no_gaps      = 1'b0;
            ready_steady = 1'b0;
            wait_for_results(200000);
        end

        write_window(COORD_W'(99999999));
        send_cluster(25, 40000000, 5000, 1'b1);
        wait_for_results(400000);

        if (oracle.outstanding() != 0) begin
            oracle.failures += oracle.outstanding();
            $display("%0d predicted pairs never arrived", oracle.outstanding());
        end
        $display("covered %0d records: %0d clears, %0d into a full store, %0d over the pair cap",
                 oracle.records_taken, oracle.clears, oracle.full_records,
                 oracle.capped_records);
        $display("%0d window writes, %0d id pairs checked, %0d failures",
                 window_writes, oracle.pairs_checked, oracle.failures);
        if (oracle.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side: after each pair, stall at random unless ready_steady is set
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                oracle.check_pair(m_tdata[0 +: ID_W], m_tdata[ID_W +: ID_W], m_tlast);
                stall = ready_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
        end
    end

endmodule
